// ===== sv/bcf_pkg.sv =====
package bcf_pkg;

    localparam int MAX_DIM_DEFAULT = 1024;

    localparam int DIM_W = 11;
    localparam int RED_W = 8;
    localparam int COORD_W = 10;
    localparam int COUNT_W = 21;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET = 11'd25;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 11'd25;
    localparam logic [RED_W-1:0] MATCH_RED_RESET = 8'd255;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_RED = 2'd2;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } bcf_q_status_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_DIVIDE,
        BACK_DONE
    } bcf_back_state_t;

endpackage

// ===== sv/bcf_front.sv =====
module bcf_front #(
    parameter int MAX_DIM = bcf_pkg::MAX_DIM_DEFAULT,
    localparam int POS_W = $clog2(MAX_DIM),
    localparam int SUM_W = 3 * POS_W,
    localparam int CNT_W = 2 * POS_W + 1,
    localparam int FRAME_W = 2 * SUM_W + CNT_W
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [bcf_pkg::RED_W-1:0]  pixel_red,
    input  logic [bcf_pkg::DIM_W-1:0]  frame_width,
    input  logic [bcf_pkg::DIM_W-1:0]  frame_height,
    input  logic [bcf_pkg::RED_W-1:0]  match_red,
    output logic                       frame_push,
    output logic [FRAME_W-1:0]         frame_data
);
    import bcf_pkg::*;

    localparam int EXT_W = POS_W + DIM_W + 1;

    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] row_reg, row_next;
    logic [SUM_W-1:0] row_sum_reg, row_sum_next;
    logic [SUM_W-1:0] col_sum_reg, col_sum_next;
    logic [CNT_W-1:0] hit_reg, hit_next;

    logic [EXT_W-1:0] width_eff;
    logic [EXT_W-1:0] height_eff;
    logic [EXT_W-1:0] width_ext;
    logic [EXT_W-1:0] height_ext;
    logic [SUM_W-1:0] row_sum_add;
    logic [SUM_W-1:0] col_sum_add;
    logic [CNT_W-1:0] hit_add;
    logic             hit;
    logic             last_col;
    logic             last_row;

    // A dimension of zero acts as one, and one above the maximum acts as the maximum.
    always_comb
    begin
        width_ext = EXT_W'(frame_width);
        height_ext = EXT_W'(frame_height);
        if (width_ext == '0)
            width_eff = EXT_W'(1);
        else if (width_ext > EXT_W'(MAX_DIM))
            width_eff = EXT_W'(MAX_DIM);
        else
            width_eff = width_ext;
        if (height_ext == '0)
            height_eff = EXT_W'(1);
        else if (height_ext > EXT_W'(MAX_DIM))
            height_eff = EXT_W'(MAX_DIM);
        else
            height_eff = height_ext;
    end

    always_comb
    begin
        hit = (pixel_red == match_red);
        row_sum_add = row_sum_reg + (hit ? SUM_W'(row_reg) : '0);
        col_sum_add = col_sum_reg + (hit ? SUM_W'(col_reg) : '0);
        hit_add = hit_reg + (hit ? CNT_W'(1) : '0);
        last_col = (EXT_W'(col_reg) + EXT_W'(1)) >= width_eff;
        last_row = (EXT_W'(row_reg) + EXT_W'(1)) >= height_eff;
        frame_push = accept && last_col && last_row;
        frame_data = {row_sum_add, col_sum_add, hit_add};
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        row_sum_next = row_sum_reg;
        col_sum_next = col_sum_reg;
        hit_next = hit_reg;
        if (accept)
        begin
            if (last_col && last_row)
            begin
                col_next = '0;
                row_next = '0;
                row_sum_next = '0;
                col_sum_next = '0;
                hit_next = '0;
            end
            else if (last_col)
            begin
                col_next = '0;
                row_next = row_reg + POS_W'(1);
                row_sum_next = row_sum_add;
                col_sum_next = col_sum_add;
                hit_next = hit_add;
            end
            else
            begin
                col_next = col_reg + POS_W'(1);
                row_sum_next = row_sum_add;
                col_sum_next = col_sum_add;
                hit_next = hit_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            row_sum_reg <= '0;
            col_sum_reg <= '0;
            hit_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            row_sum_reg <= row_sum_next;
            col_sum_reg <= col_sum_next;
            hit_reg <= hit_next;
        end
    end

    // Handing a frame over must leave the position and sums cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_push |=> (col_reg == '0) && (row_reg == '0) && (hit_reg == '0))
        else $error("frame state not cleared after frame end");

endmodule

// ===== sv/bcf_queue.sv =====
module bcf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bcf_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [WIDTH-1:0]       push_data,
    input  logic                   pop,
    output logic [WIDTH-1:0]       pop_data,
    output bcf_pkg::bcf_q_status_t status
);
    import bcf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    always_comb
    begin
        status.full = (count_reg == CNT_W'(DEPTH));
        status.empty = (count_reg == '0);
        do_push = push && !status.full;
        do_pop = pop && !status.empty;
        pop_data = entry_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds its depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("frame pushed into a full queue");

endmodule

// ===== sv/bcf_back.sv =====
module bcf_back #(
    parameter int MAX_DIM = bcf_pkg::MAX_DIM_DEFAULT,
    localparam int POS_W = $clog2(MAX_DIM),
    localparam int SUM_W = 3 * POS_W,
    localparam int CNT_W = 2 * POS_W + 1,
    localparam int FRAME_W = 2 * SUM_W + CNT_W
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bcf_pkg::bcf_q_status_t       q_status,
    input  logic [FRAME_W-1:0]           frame_data,
    output logic                         q_pop,
    input  logic                         pop,
    output logic                         empty,
    output logic [bcf_pkg::COORD_W-1:0]  centroid_row,
    output logic [bcf_pkg::COORD_W-1:0]  centroid_col,
    output logic [bcf_pkg::COUNT_W-1:0]  match_count,
    output logic                         blob_found
);
    import bcf_pkg::*;

    localparam int DIV_W = SUM_W + 1;
    localparam int STEP_W = (POS_W > 1) ? $clog2(POS_W) : 1;

    bcf_back_state_t state_reg, state_next;

    logic [SUM_W-1:0]  rem_row_reg, rem_row_next;
    logic [SUM_W-1:0]  rem_col_reg, rem_col_next;
    logic [DIV_W-1:0]  div_reg, div_next;
    logic [POS_W-1:0]  q_row_reg, q_row_next;
    logic [POS_W-1:0]  q_col_reg, q_col_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic [SUM_W-1:0]  in_row_sum;
    logic [SUM_W-1:0]  in_col_sum;
    logic [CNT_W-1:0]  in_count;
    logic              row_ge;
    logic              col_ge;
    logic              load;
    logic              step_en;
    logic              found;
    logic [COORD_W+POS_W-1:0] row_wide;
    logic [COORD_W+POS_W-1:0] col_wide;
    logic [COUNT_W+CNT_W-1:0] count_wide;

    assign {in_row_sum, in_col_sum, in_count} = frame_data;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BACK_IDLE:
                if (!q_status.empty)
                    state_next = BACK_DIVIDE;
            BACK_DIVIDE:
                if (step_reg == '0)
                    state_next = BACK_DONE;
            BACK_DONE:
                if (pop)
                    state_next = BACK_IDLE;
            default:
                state_next = BACK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop = (state_reg == BACK_IDLE) && !q_status.empty;
        load = q_pop;
        step_en = (state_reg == BACK_DIVIDE);
        empty = (state_reg != BACK_DONE);
    end

    // Restoring division, one quotient bit per cycle for the row and the column together.
    // The mean cannot exceed the last position, so the quotient fits in the position width.
    always_comb
    begin
        row_ge = {1'b0, rem_row_reg} >= div_reg;
        col_ge = {1'b0, rem_col_reg} >= div_reg;
        rem_row_next = rem_row_reg;
        rem_col_next = rem_col_reg;
        div_next = div_reg;
        q_row_next = q_row_reg;
        q_col_next = q_col_reg;
        cnt_next = cnt_reg;
        step_next = step_reg;
        if (load)
        begin
            rem_row_next = in_row_sum;
            rem_col_next = in_col_sum;
            div_next = DIV_W'(in_count) << (POS_W - 1);
            q_row_next = '0;
            q_col_next = '0;
            cnt_next = in_count;
            step_next = STEP_W'(POS_W - 1);
        end
        else if (step_en)
        begin
            if (row_ge)
                rem_row_next = rem_row_reg - div_reg[SUM_W-1:0];
            if (col_ge)
                rem_col_next = rem_col_reg - div_reg[SUM_W-1:0];
            q_row_next = POS_W'({q_row_reg, row_ge});
            q_col_next = POS_W'({q_col_reg, col_ge});
            div_next = div_reg >> 1;
            step_next = step_reg - STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BACK_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        rem_row_reg <= rem_row_next;
        rem_col_reg <= rem_col_next;
        div_reg <= div_next;
        q_row_reg <= q_row_next;
        q_col_reg <= q_col_next;
        cnt_reg <= cnt_next;
        step_reg <= step_next;
    end

    // An empty frame reports zero coordinates in place of the divider's output.
    always_comb
    begin
        found = (cnt_reg != '0);
        row_wide = {{COORD_W{1'b0}}, q_row_reg};
        col_wide = {{COORD_W{1'b0}}, q_col_reg};
        count_wide = {{COUNT_W{1'b0}}, cnt_reg};
        centroid_row = found ? row_wide[COORD_W-1:0] : '0;
        centroid_col = found ? col_wide[COORD_W-1:0] : '0;
        match_count = count_wide[COUNT_W-1:0];
        blob_found = found;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BACK_DIVIDE) && (step_reg == '0) |=> state_reg == BACK_DONE)
        else $error("division did not finish after its last step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BACK_DONE) && !pop |=> (state_reg == BACK_DONE) && $stable(q_row_reg)
            && $stable(q_col_reg) && $stable(cnt_reg))
        else $error("waiting result changed before it was taken");

endmodule

// ===== sv/blob_centroid_finder_unit.sv =====
// Flow: the sums of a frame enter the queue when its last pixel is accepted, and the
// back end takes them while idle, divides, and holds the result until it is popped.
// Throughput: one pixel per cycle until the two-frame queue fills; the back end works
// on one frame at a time and takes no new one until the waiting result is popped.
// Reset: asynchronous and active low; it clears position, sums, the queue and the
// back end's state, and sets the registers to a 25 by 25 frame with match value 255.
module blob_centroid_finder_unit #(
    parameter int MAX_DIM = bcf_pkg::MAX_DIM_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [bcf_pkg::RED_W-1:0]       pixel_red,
    output logic                            empty,
    input  logic                            pop,
    output logic [bcf_pkg::COORD_W-1:0]     centroid_row,
    output logic [bcf_pkg::COORD_W-1:0]     centroid_col,
    output logic [bcf_pkg::COUNT_W-1:0]     match_count,
    output logic                            blob_found,
    input  logic                            cfg_write,
    input  logic [bcf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bcf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bcf_pkg::*;

    localparam int POS_W = $clog2(MAX_DIM);
    localparam int SUM_W = 3 * POS_W;
    localparam int CNT_W = 2 * POS_W + 1;
    localparam int FRAME_W = 2 * SUM_W + CNT_W;

    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;
    logic [RED_W-1:0] match_red_reg;

    bcf_q_status_t    q_status;
    logic             accept;
    logic             frame_push;
    logic             q_pop;
    logic [FRAME_W-1:0] push_data;
    logic [FRAME_W-1:0] pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
            match_red_reg <= MATCH_RED_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg <= cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DIM_W-1:0];
                REG_MATCH_RED:    match_red_reg <= cfg_data[RED_W-1:0];
                default:          ;
            endcase
        end
    end

    assign full = q_status.full;
    assign accept = push && !q_status.full;

    bcf_front #(
        .MAX_DIM(MAX_DIM)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .accept(accept),
        .pixel_red(pixel_red),
        .frame_width(frame_width_reg),
        .frame_height(frame_height_reg),
        .match_red(match_red_reg),
        .frame_push(frame_push),
        .frame_data(push_data)
    );

    bcf_queue #(
        .WIDTH(FRAME_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(frame_push),
        .push_data(push_data),
        .pop(q_pop),
        .pop_data(pop_data),
        .status(q_status)
    );

    bcf_back #(
        .MAX_DIM(MAX_DIM)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_status(q_status),
        .frame_data(pop_data),
        .q_pop(q_pop),
        .pop(pop),
        .empty(empty),
        .centroid_row(centroid_row),
        .centroid_col(centroid_col),
        .match_count(match_count),
        .blob_found(blob_found)
    );

endmodule
